[rtl/core/amvf_pkg.sv]
// Shared types and constants of the ADC medoid voltage filter.
package amvf_pkg;

  // Field widths.
  localparam int SAMPLE_W = 12;
  localparam int SCALE_W  = 10;
  localparam int PROD_W   = SAMPLE_W + SCALE_W;

  // Stream data widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Full-scale voltage after reset, in hundredths of a volt.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd660;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;  // rewind the search counters
    logic wr;     // store the incoming sample
    logic rd;     // read the pivot and the partner entry
    logic acc;    // add one absolute difference to the running sum
    logic cmp;    // close a row and keep the best candidate
    logic mul;    // scale the chosen sample
    logic load;   // move the result into the output register
  } amvf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;  // the next sample completes the window
    logic k_last;     // partner index is at the last entry
    logic p_last;     // pivot index is at the last entry
    logic out_free;   // the output register can take a result this cycle
  } amvf_sts_t;

endpackage

[rtl/core/amvf_ctrl.sv]
// Controller state machine that sequences filling, medoid search and output.
module amvf_ctrl
  import amvf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  amvf_sts_t sts,
  output amvf_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_ACC,
    ST_CMP,
    ST_MUL,
    ST_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Samples are taken only while no search is running.
  assign in_tready = (state_r == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.wr = 1'b1;
          if (sts.fill_last) begin
            cmd.start = 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.k_last ? ST_CMP : ST_RD;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = sts.p_last ? ST_MUL : ST_RD;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/amvf_dp.sv]
// Datapath: window memory, distance accumulator, best tracker, scaler, output register.
module amvf_dp
  import amvf_pkg::*;
#(
  parameter int WINDOW = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  amvf_cmd_t              cmd,
  output amvf_sts_t              sts,
  input  logic [SAMPLE_W-1:0]    in_sample,
  input  logic                   cfg_wr_en,
  input  logic [SCALE_W-1:0]     cfg_wr_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_W-1:0]    out_chosen_sample,
  output logic [SCALE_W-1:0]     out_voltage_centivolts
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = SAMPLE_W + IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  logic [SAMPLE_W-1:0] mem_r [WINDOW];
  logic [IDX_W-1:0]    fill_r;
  logic [IDX_W-1:0]    p_r;
  logic [IDX_W-1:0]    k_r;
  logic [SAMPLE_W-1:0] rd_a_r;
  logic [SAMPLE_W-1:0] rd_b_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    sum_nxt;
  logic [SUM_W-1:0]    best_sum_r;
  logic [SAMPLE_W-1:0] best_val_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [SAMPLE_W-1:0] diff;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [SCALE_W-1:0]  out_volt_r;

  // Status toward the controller.
  assign sts.fill_last = (fill_r == IDX_LAST);
  assign sts.k_last    = (k_r == IDX_LAST);
  assign sts.p_last    = (p_r == IDX_LAST);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Absolute difference of the two registered entries and the running sum.
  assign diff    = (rd_a_r > rd_b_r) ? (rd_a_r - rd_b_r) : (rd_b_r - rd_a_r);
  assign sum_nxt = sum_r + SUM_W'(diff);

  // Window memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_r[fill_r] <= in_sample;
    end
    if (cmd.rd) begin
      rd_a_r <= mem_r[p_r];
      rd_b_r <= mem_r[k_r];
    end
  end

  // Fill count and search indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      p_r    <= '0;
      k_r    <= '0;
    end else begin
      if (cmd.wr) begin
        fill_r <= sts.fill_last ? '0 : fill_r + IDX_ONE;
      end
      if (cmd.start) begin
        p_r <= '0;
        k_r <= '0;
      end else begin
        if (cmd.acc) begin
          k_r <= sts.k_last ? '0 : k_r + IDX_ONE;
        end
        if (cmd.cmp) begin
          p_r <= sts.p_last ? '0 : p_r + IDX_ONE;
        end
      end
    end
  end

  // Distance accumulation and best candidate; a tie keeps the earlier entry.
  always_ff @(posedge clk) begin
    if (cmd.start || cmd.cmp) begin
      sum_r <= '0;
    end else if (cmd.acc) begin
      sum_r <= sum_nxt;
    end
    if (cmd.cmp && ((p_r == '0) || (sum_r < best_sum_r))) begin
      best_sum_r <= sum_r;
      best_val_r <= rd_a_r;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(best_val_r) * PROD_W'(scale_r);
    end
  end

  // Full-scale register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  // Output register; it holds a result until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_sample_r <= best_val_r;
      out_volt_r   <= prod_r[PROD_W-1:SAMPLE_W];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_chosen_sample      = out_sample_r;
  assign out_voltage_centivolts = out_volt_r;

  // A row closes only after the partner index has wrapped.
  a_cmp_after_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cmp |-> (k_r == '0))
    else $error("row closed before all partners were summed");

  // Each accumulation uses data read in the cycle before.
  a_acc_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> $past(cmd.rd))
    else $error("accumulate without a preceding read");

  // A new result never overwrites one still waiting.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending result");

endmodule

[rtl/core/adc_medoid_voltage_filter.sv]
// Top level of the ADC medoid voltage filter.
//
// Samples are accepted one per cycle while a window of WINDOW entries fills.
// The sample that completes the window starts the medoid search: a read
// and an accumulate step for each pair of entries, a compare step per row,
// then a scale step and a load step that waits for a free output register;
// no sample is accepted during it. The search is paced by the single
// subtract-accumulate unit, each difference fed by its own pair of memory
// reads. A finished result waits in the output register while the next
// window fills. The voltage is floor(chosen_sample * full_scale / 4096),
// with full scale set through the configuration port (660 after reset).
module adc_medoid_voltage_filter
  import amvf_pkg::*;
#(
  parameter int WINDOW = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream; tdata: sample [11:0], zeros above.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Result stream; tdata: chosen_sample [11:0], voltage_centivolts [21:12], zeros above.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Full-scale register write.
  input  logic                   cfg_wr_en,
  input  logic [SCALE_W-1:0]     cfg_wr_data
);

  amvf_cmd_t           cmd;
  amvf_sts_t           sts;
  logic [SAMPLE_W-1:0] chosen_sample;
  logic [SCALE_W-1:0]  voltage_centivolts;

  // Sequencing.
  amvf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  amvf_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_sample              (in_tdata[SAMPLE_W-1:0]),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .out_valid              (out_tvalid),
    .out_ready              (out_tready),
    .out_chosen_sample      (chosen_sample),
    .out_voltage_centivolts (voltage_centivolts)
  );

  // Pack the result fields.
  assign out_tdata = {(OUT_TDATA_W - PROD_W)'(0), voltage_centivolts, chosen_sample};

  // The transaction that completes a window starts the search at once.
  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && sts.fill_last) |=> !in_tready)
    else $error("search did not start after the window completed");

  // Samples are stored only while no search is running.
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> !(cmd.rd || cmd.acc || cmd.cmp || cmd.mul || cmd.load))
    else $error("sample written during the search");

  // A result appears only after a load.
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.load))
    else $error("result valid without a load");

endmodule

[tb/sv/adc_medoid_voltage_filter_tb.sv]
// Testbench for the ADC medoid voltage filter: random and directed samples checked against a predictor.
`timescale 1ns / 1ps

import amvf_pkg::*;

// One expected result of a completed window.
typedef struct packed {
  logic [SAMPLE_W-1:0] chosen_sample;
  logic [SCALE_W-1:0]  voltage_centivolts;
} medoid_result_t;

// Keeps its own copy of the window and the full-scale setting, and queues the
// result that each completed window must produce.
class medoid_scoreboard;
  int unsigned         window_len;
  logic [SAMPLE_W-1:0] window_samples[];
  int unsigned         fill_count;
  logic [SCALE_W-1:0]  full_scale;
  medoid_result_t      expected_results[$];
  int unsigned         error_count;

  function new(int unsigned len);
    window_len     = len;
    window_samples = new[len];
    fill_count     = 0;
    full_scale     = SCALE_RESET;
    error_count    = 0;
  endfunction

  function void set_full_scale(logic [SCALE_W-1:0] value);
    full_scale = value;
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  // Sample with the least sum of absolute differences; the earliest wins a tie.
  function logic [SAMPLE_W-1:0] medoid_of_window();
    int unsigned best_sum;
    int unsigned row_sum;
    int          best_pos;
    int          a;
    int          b;
    best_pos = 0;
    best_sum = 0;
    for (int p = 0; p < window_len; p++) begin
      row_sum = 0;
      for (int k = 0; k < window_len; k++) begin
        a = window_samples[p];
        b = window_samples[k];
        row_sum += (a > b) ? (a - b) : (b - a);
      end
      if (p == 0 || row_sum < best_sum) begin
        best_sum = row_sum;
        best_pos = p;
      end
    end
    return window_samples[best_pos];
  endfunction

  // Called for every accepted input transaction.
  function void note_sample(logic [SAMPLE_W-1:0] sample);
    medoid_result_t      res;
    logic [PROD_W-1:0]   product;
    window_samples[fill_count] = sample;
    fill_count++;
    if (fill_count < window_len) return;
    fill_count = 0;
    res.chosen_sample      = medoid_of_window();
    product                = res.chosen_sample * full_scale;
    res.voltage_centivolts = product[PROD_W-1:SAMPLE_W];
    expected_results.push_back(res);
  endfunction

  // Called for every accepted output transaction.
  function void check_result(logic [OUT_TDATA_W-1:0] tdata);
    medoid_result_t      want;
    logic [SAMPLE_W-1:0] got_sample;
    logic [SCALE_W-1:0]  got_volts;
    got_sample = tdata[SAMPLE_W-1:0];
    got_volts  = tdata[SAMPLE_W +: SCALE_W];
    if (expected_results.size() == 0) begin
      $error("result with no expected transaction: chosen_sample %0d, voltage_centivolts %0d",
             got_sample, got_volts);
      error_count++;
      return;
    end
    want = expected_results.pop_front();
    if (got_sample !== want.chosen_sample) begin
      $error("chosen_sample: expected %0d, actual %0d", want.chosen_sample, got_sample);
      error_count++;
    end
    if (got_volts !== want.voltage_centivolts) begin
      $error("voltage_centivolts: expected %0d, actual %0d", want.voltage_centivolts, got_volts);
      error_count++;
    end
  endfunction
endclass

module adc_medoid_voltage_filter_tb;
  localparam int WINDOW_LEN   = 4;
  localparam int SETTLE_CYC   = 60;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_ITEMS  = 106;
  localparam int DIRECTED_LEN = 20;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [SCALE_W-1:0]     cfg_wr_data;

  medoid_scoreboard sb = new(WINDOW_LEN);

  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  int unsigned hold_len  = 0;
  int unsigned cycle_count = 0;

  // Zeros, extremes, ties at the first entry and ties further in.
  logic [SAMPLE_W-1:0] directed_samples[DIRECTED_LEN] = '{
    12'd0,    12'd0, 12'd0,    12'd0,
    12'd4095, 12'd4095, 12'd4095, 12'd4095,
    12'd0,    12'd4095, 12'd0,    12'd4095,
    12'd4095, 12'd0,    12'd4095, 12'd0,
    12'd10,   12'd20,   12'd30,   12'd40
  };

  adc_medoid_voltage_filter #(
    .WINDOW(WINDOW_LEN)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("adc_medoid_voltage_filter_tb: FAIL");
      $finish;
    end
  end

  // Offers one sample and waits until the transaction is accepted.
  task automatic send_sample(logic [SAMPLE_W-1:0] sample);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - SAMPLE_W){1'b0}}, sample};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(sample);
  endtask

  // Stops offering and waits until the block is idle again.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_full_scale(logic [SCALE_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_full_scale(value);
  endtask

  // Mix of extremes, repeats and near neighbors so that ties come up often.
  function automatic logic [SAMPLE_W-1:0] next_sample(logic [SAMPLE_W-1:0] prev);
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 1) ? 4095 : 0;
      1: v = prev;
      2: begin
        v = int'(prev) + $urandom_range(0, 16) - 8;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      default: v = $urandom_range(0, 4095);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // Result side: random stalls, one long hold-off, and a check per transaction.
  initial begin
    int unsigned gap;
    int unsigned hold;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len != 0) begin
        hold       = hold_len;
        hold_len   = 0;
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      gap = recv_gaps ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
    end
  end

  // Stimulus: reset, directed windows, then random phases at several full scales.
  initial begin
    logic [SAMPLE_W-1:0] prev;
    logic [SCALE_W-1:0]  phase_scale[RAND_PHASES];
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed windows at the full scale left by reset.
    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    drain();

    // Largest full scale gives the largest voltage.
    write_full_scale(10'd1023);
    repeat (WINDOW_LEN) send_sample(12'd4095);
    drain();

    // Zero full scale gives zero volts whatever the sample.
    write_full_scale(10'd0);
    send_sample(12'd4095);
    send_sample(12'd4094);
    send_sample(12'd4095);
    send_sample(12'd1);
    drain();

    // Random phases; idling is switched off on one side or both in some.
    phase_scale = '{10'($urandom_range(0, 1023)), 10'd1, 10'd512,
                    10'($urandom_range(0, 1023)), SCALE_RESET};
    prev = '0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_full_scale(phase_scale[p]);
      send_gaps = (p != 1 && p != 3);
      recv_gaps = (p != 2 && p != 3);
      if (p == 1) hold_len = LONG_HOLD;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        prev = next_sample(prev);
        send_sample(prev);
      end
      drain();
    end

    if (sb.error_count == 0) begin
      $display("adc_medoid_voltage_filter_tb: PASS");
    end else begin
      $display("adc_medoid_voltage_filter_tb: FAIL");
    end
    $finish;
  end

endmodule

[adc_medoid_voltage_filter.f]
rtl/core/amvf_pkg.sv
rtl/core/amvf_ctrl.sv
rtl/core/amvf_dp.sv
rtl/core/adc_medoid_voltage_filter.sv
tb/sv/adc_medoid_voltage_filter_tb.sv
